@@ rtl/core/lrupr_pkg.sv @@
// Shared constants and controller/datapath interface types for the LRU page replacement core.
package lrupr_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;
  localparam int CFG_W         = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;
  localparam int COUNT_W       = 16;

  typedef struct packed {
    logic load;    // capture page, clear scan results
    logic scan;    // walk frames
    logic update;  // commit table update and result
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

@@ rtl/core/lrupr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lrupr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/lrupr_ctrl.sv @@
// Controller state machine: sequences load, frame scan and update for one beat.
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ rtl/core/lrupr_dpath.sv @@
// Datapath: page RAM, valid bits, age ranks, scan trackers, fault counter and result registers.
module lrupr_dpath
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  localparam int FIDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  logic [PAGE_BITS-1:0] in_page_number,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output logic                 out_fault,
  output logic [FIDX_W-1:0]    out_frame_index,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [COUNT_W-1:0]   out_fault_total
);

  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  logic [CFG_W-1:0]     cfg_r;
  logic [PAGE_BITS-1:0] page_r;

  logic [CNT_W-1:0]     cnt_r;
  logic [FIDX_W-1:0]    cidx_r;

  logic                 valid_r [FRAMES];
  logic [FIDX_W-1:0]    age_r   [FRAMES];
  logic [FIDX_W-1:0]    age_nxt [FRAMES];

  // scan trackers
  logic [CNT_W-1:0]     used_r;
  logic                 hit_r;
  logic [FIDX_W-1:0]    hit_idx_r;
  logic [FIDX_W-1:0]    hit_rank_r;
  logic                 lru_found_r;
  logic [FIDX_W-1:0]    lru_rank_r;
  logic [FIDX_W-1:0]    lru_idx_r;
  logic [PAGE_BITS-1:0] victim_r;
  logic                 free_found_r;
  logic [FIDX_W-1:0]    free_idx_r;

  logic [COUNT_W-1:0]   fcnt_r, fcnt_nxt;

  logic                 out_valid_r;
  logic                 out_fault_r;
  logic [FIDX_W-1:0]    out_fidx_r;
  logic                 out_ev_r;
  logic [PAGE_BITS-1:0] out_evpage_r;
  logic [COUNT_W-1:0]   out_ftot_r;

  logic [PAGE_BITS-1:0] rd_data;
  logic                 cmp_en;
  logic                 cur_valid;
  logic [FIDX_W-1:0]    cur_rank;

  logic [LIM_W-1:0]     limit;
  logic                 has_room;
  logic                 evict;
  logic [FIDX_W-1:0]    tgt;

  lrupr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (cmd.update && !hit_r),
    .waddr (tgt),
    .wdata (page_r),
    .raddr (cnt_r[FIDX_W-1:0]),
    .rdata (rd_data)
  );

  assign stat.scan_done = (cnt_r == CNT_W'(FRAMES));

  // read data for frame cidx_r arrives in the cycle after its address
  assign cmp_en    = cmd.scan && (cnt_r != '0);
  assign cur_valid = valid_r[cidx_r];
  assign cur_rank  = age_r[cidx_r];

  always_comb begin
    if (cfg_r == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(cfg_r) > LIM_W'(FRAMES)) begin
      limit = LIM_W'(FRAMES);
    end else begin
      limit = LIM_W'(cfg_r);
    end
  end

  assign has_room = (LIM_W'(used_r) < limit);
  assign evict    = !hit_r && !has_room;

  always_comb begin
    if (hit_r) begin
      tgt = hit_idx_r;
    end else if (has_room) begin
      tgt = free_idx_r;
    end else begin
      tgt = lru_idx_r;
    end
  end

  assign fcnt_nxt = (fcnt_r == '1) ? fcnt_r : fcnt_r + COUNT_W'(1);

  // touch: valid frames younger than the touched one age by one; on a fault all other valid frames age
  always_comb begin
    for (int k = 0; k < FRAMES; k++) begin
      age_nxt[k] = age_r[k];
      if (FIDX_W'(k) == tgt) begin
        age_nxt[k] = '0;
      end else if (valid_r[k] && (!hit_r || age_r[k] < hit_rank_r)) begin
        age_nxt[k] = age_r[k] + FIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < FRAMES; k++) begin
        valid_r[k] <= 1'b0;
        age_r[k]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      out_valid_r <= cmd.update;
      if (cmd.update) begin
        for (int k = 0; k < FRAMES; k++) begin
          age_r[k] <= age_nxt[k];
        end
        if (!hit_r) begin
          valid_r[tgt] <= 1'b1;
          fcnt_r       <= fcnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      hit_r        <= 1'b0;
      lru_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      used_r       <= '0;
    end else if (cmd.load) begin
      cnt_r        <= '0;
      hit_r        <= 1'b0;
      lru_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      used_r       <= '0;
    end else if (cmd.scan) begin
      if (!stat.scan_done) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmp_en) begin
        if (cur_valid) begin
          used_r <= used_r + CNT_W'(1);
          if (!hit_r && rd_data == page_r) begin
            hit_r <= 1'b1;
          end
          if (!lru_found_r || cur_rank > lru_rank_r) begin
            lru_found_r <= 1'b1;
          end
        end else if (!free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  // payload side of the scan trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page_number;
    end
    cidx_r <= cnt_r[FIDX_W-1:0];
    if (cmp_en) begin
      if (cur_valid) begin
        if (!hit_r && rd_data == page_r) begin
          hit_idx_r  <= cidx_r;
          hit_rank_r <= cur_rank;
        end
        if (!lru_found_r || cur_rank > lru_rank_r) begin
          lru_rank_r <= cur_rank;
          lru_idx_r  <= cidx_r;
          victim_r   <= rd_data;
        end
      end else if (!free_found_r) begin
        free_idx_r <= cidx_r;
      end
    end
    if (cmd.update) begin
      out_fault_r  <= !hit_r;
      out_fidx_r   <= tgt;
      out_ev_r     <= evict;
      out_evpage_r <= evict ? victim_r : '0;
      out_ftot_r   <= hit_r ? fcnt_r : fcnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_frame_index   = out_fidx_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_evpage_r;
  assign out_fault_total   = out_ftot_r;

endmodule

@@ rtl/core/lru_page_replacement_core.sv @@
// Top level of the LRU page replacement core: controller plus datapath.
//
// Fully associative page frame table with least-recently-used replacement.
// Input: pulse start with in_page_number while busy is low; that edge takes the beat.
// Output: one result beat per input, shown for exactly one cycle with out_valid
//   high: out_fault, out_frame_index, out_evicted_valid, out_evicted_page
//   (zero when nothing is evicted) and out_fault_total (saturating).
// Config: cfg_we with cfg_wdata writes the frame limit (0 acts as 1, values above
//   FRAMES act as FRAMES); write it only while busy is low. Reset value is 4.
// Timing: the frame scan reads the page RAM one frame per cycle, then the update
//   state commits the table. out_valid rises registered from the update state;
//   busy drops in that same cycle. No new beat is taken while busy is high, so
//   the one-read-per-cycle page RAM scan sets how often beats can be taken.
// Reset (rst_n low, synchronous): all frames empty, age ranks and fault count
//   cleared, frame limit back to 4, no result pending.
// The receiver has no stall: each result must be taken in its one valid cycle.
module lru_page_replacement_core
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  localparam int FIDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] in_page_number,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output logic                 out_fault,
  output logic [FIDX_W-1:0]    out_frame_index,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [COUNT_W-1:0]   out_fault_total
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lrupr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lrupr_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_page_number    (in_page_number),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_fault         (out_fault),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

endmodule

@@ dv/tb_lru_page_replacement_core.sv @@
// Self-checking testbench for lru_page_replacement_core: directed table and random traffic.
`timescale 1ns / 1ps

module tb_lru_page_replacement_core;
  import lrupr_pkg::*;

  localparam int NFRAMES        = FRAMES_DEF;
  localparam int PW             = PAGE_BITS_DEF;
  localparam logic [COUNT_W-1:0] FAULTS_MAX = '1;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int HOT_MAX        = 12;

  typedef struct packed {
    logic               fault;
    logic [2:0]         frame;
    logic               evv;
    logic [PW-1:0]      evp;
    logic [COUNT_W-1:0] total;
  } lru_res_t;

  typedef enum logic {ROW_PAGE, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [PW-1:0] val;
    logic          typed;
    lru_res_t      res;
  } dir_row_t;

  localparam int N_ROWS = 25;

  // limit starts at 4 after reset
  dir_row_t dir_rows [N_ROWS] = '{
    '{ROW_PAGE,  16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd1}},
    '{ROW_PAGE,  16'hFFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 16'd2}},
    '{ROW_PAGE,  16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd2}},
    '{ROW_PAGE,  16'h5555, 1'b1, '{1'b1, 3'd2, 1'b0, 16'h0000, 16'd3}},
    '{ROW_PAGE,  16'hAAAA, 1'b1, '{1'b1, 3'd3, 1'b0, 16'h0000, 16'd4}},
    '{ROW_PAGE,  16'h1234, 1'b1, '{1'b1, 3'd1, 1'b1, 16'hFFFF, 16'd5}},
    '{ROW_PAGE,  16'h5555, 1'b0, '0},
    '{ROW_LIMIT, 16'd8,    1'b0, '0},
    '{ROW_PAGE,  16'h0001, 1'b0, '0},
    '{ROW_PAGE,  16'h0002, 1'b0, '0},
    '{ROW_PAGE,  16'h0003, 1'b0, '0},
    '{ROW_PAGE,  16'h0004, 1'b0, '0},
    '{ROW_PAGE,  16'h8000, 1'b0, '0},
    // limit 0 acts as 1; the eight resident pages stay
    '{ROW_LIMIT, 16'd0,    1'b0, '0},
    '{ROW_PAGE,  16'h0002, 1'b0, '0},
    '{ROW_PAGE,  16'h7FFF, 1'b0, '0},
    '{ROW_PAGE,  16'h4321, 1'b0, '0},
    '{ROW_LIMIT, 16'd15,   1'b0, '0},
    '{ROW_PAGE,  16'h0F0F, 1'b0, '0},
    '{ROW_LIMIT, 16'd9,    1'b0, '0},
    '{ROW_PAGE,  16'h0002, 1'b0, '0},
    '{ROW_PAGE,  16'hF0F0, 1'b0, '0},
    '{ROW_LIMIT, 16'd1,    1'b0, '0},
    '{ROW_PAGE,  16'h0001, 1'b0, '0},
    '{ROW_PAGE,  16'h0001, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [PW-1:0]      in_page_number = '0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               out_valid;
  logic               out_fault;
  logic [2:0]         out_frame_index;
  logic               out_evicted_valid;
  logic [PW-1:0]      out_evicted_page;
  logic [COUNT_W-1:0] out_fault_total;

  // predicted frame table
  logic [PW-1:0]      pt_page  [NFRAMES];
  bit                 pt_valid [NFRAMES];
  int                 pt_rank  [NFRAMES];
  logic [COUNT_W-1:0] pt_faults;
  int                 pt_limit;

  lru_res_t           due_results [$];
  lru_res_t           result_want;
  logic [PW-1:0]      hot_pages [HOT_MAX];
  int                 hot_n;
  int                 err_count = 0;
  int                 quiet_cycles = 0;

  always #5 clk = ~clk;

  lru_page_replacement_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_fault        (out_fault),
    .out_frame_index  (out_frame_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_total  (out_fault_total)
  );

  // frame f becomes most recent; valid frames younger than rank r age by one
  function automatic void age_to_front(int f, int r);
    for (int k = 0; k < NFRAMES; k++) begin
      if (pt_valid[k] && k != f && pt_rank[k] < r) pt_rank[k]++;
    end
    pt_rank[f] = 0;
  endfunction

  function automatic lru_res_t replace_page(logic [PW-1:0] pg);
    lru_res_t r;
    int lim, used, f, best;
    bit hit, found;
    r = '0;
    used = 0;
    f = 0;
    hit = 1'b0;
    lim = pt_limit;
    if (lim < 1) lim = 1;
    if (lim > NFRAMES) lim = NFRAMES;
    for (int k = 0; k < NFRAMES; k++) begin
      if (pt_valid[k]) begin
        used++;
        if (!hit && pt_page[k] == pg) begin
          hit = 1'b1;
          f = k;
        end
      end
    end
    if (hit) begin
      age_to_front(f, pt_rank[f]);
    end else begin
      if (used < lim) begin
        for (int k = NFRAMES - 1; k >= 0; k--) if (!pt_valid[k]) f = k;
        pt_valid[f] = 1'b1;
      end else begin
        found = 1'b0;
        best = 0;
        for (int k = 0; k < NFRAMES; k++) begin
          if (pt_valid[k] && (!found || pt_rank[k] > best)) begin
            found = 1'b1;
            best = pt_rank[k];
            f = k;
          end
        end
        r.evv = 1'b1;
        r.evp = pt_page[f];
      end
      pt_page[f] = pg;
      age_to_front(f, NFRAMES);
      if (pt_faults != FAULTS_MAX) pt_faults++;
    end
    r.fault = !hit;
    r.frame = f[2:0];
    r.total = pt_faults;
    return r;
  endfunction

  // hold start until the beat is taken, then queue its result
  task automatic send_page(input logic [PW-1:0] pg, input logic typed, input lru_res_t typed_res);
    lru_res_t p;
    in_page_number <= pg;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    p = replace_page(pg);
    due_results.push_back(typed ? typed_res : p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (due_results.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] v);
    drain();
    repeat (2) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    pt_limit = v;
  endtask

  task automatic idle_gap(input int pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(0, 99) < pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [PW-1:0] want, input logic [PW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, actual frame %0d page %0h",
                 $time, out_frame_index, out_evicted_page);
        err_count++;
      end else begin
        result_want = due_results.pop_front();
        check_field("fault", PW'(result_want.fault), PW'(out_fault));
        check_field("frame_index", PW'(result_want.frame), PW'(out_frame_index));
        check_field("evicted_valid", PW'(result_want.evv), PW'(out_evicted_valid));
        check_field("evicted_page", result_want.evp, out_evicted_page);
        check_field("fault_total", PW'(result_want.total), PW'(out_fault_total));
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int pct, n;
    logic [CFG_W-1:0] lv;
    logic [PW-1:0] pg;
    for (int k = 0; k < NFRAMES; k++) begin
      pt_page[k] = '0;
      pt_valid[k] = 1'b0;
      pt_rank[k] = 0;
    end
    pt_faults = '0;
    pt_limit = CFG_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_LIMIT) set_limit(dir_rows[i].val[CFG_W-1:0]);
      else send_page(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
    end

    // three idle profiles: light, heavy, none
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 7 : (ph == 1) ? 69 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        if (seg == 0) lv = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd8 : 4'd0;
        else if (seg == 1 && ph == 2) lv = 4'd15;
        else if ($urandom_range(0, 9) < 8) lv = CFG_W'($urandom_range(1, NFRAMES));
        else lv = CFG_W'($urandom_range(0, 15));
        set_limit(lv);
        // working set sometimes fits the limit, sometimes thrashes
        hot_n = $urandom_range(2, HOT_MAX);
        for (int k = 0; k < HOT_MAX; k++) hot_pages[k] = PW'($urandom);
        n = $urandom_range(55, 90);
        for (int j = 0; j < n; j++) begin
          idle_gap(pct);
          if (ph != 2 && $urandom_range(0, 99) < 3) drain();
          if ($urandom_range(0, 99) < 85) pg = hot_pages[$urandom_range(0, hot_n - 1)];
          else pg = PW'($urandom);
          send_page(pg, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
